// ===== design/sfb_pkg.sv =====
package sfb_pkg;

  // One byte of the outgoing stream plus its side flags
  typedef struct packed {
    logic [7:0] data;
    logic       frame_end;
    logic       rejected;
  } frame_byte_t;

  localparam int unsigned BURST_DEPTH = 7;
  localparam int unsigned BURST_CNT_W = 3;

  // Result burst produced by one input transaction
  typedef struct packed {
    logic [BURST_CNT_W-1:0]             cnt;
    frame_byte_t [BURST_DEPTH-1:0]      ent;
  } burst_load_t;

  localparam logic       OP_START   = 1'b0;
  localparam logic       OP_PAYLOAD = 1'b1;

  localparam logic [2:0] CFG_HEADER_FIRST  = 3'd0;
  localparam logic [2:0] CFG_HEADER_SECOND = 3'd1;
  localparam logic [2:0] CFG_TAIL_BYTE     = 3'd2;
  localparam logic [2:0] CFG_MAX_FRAME_LEN = 3'd3;
  localparam logic [2:0] CFG_CRC_INITIAL   = 3'd4;

  localparam logic [8:0]  OVERHEAD_BYTES = 9'd7;
  localparam logic [15:0] CRC_POLY       = 16'h1021;

  // CRC-16, MSB first, one byte folded in
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== design/serial_frame_builder_crc16_unit.sv =====
// Serial frame builder with CRC-16/CCITT (poly 0x1021, MSB first, no final
// XOR). A start transaction (op 0) emits header_first, header_second, command
// and length; each payload transaction (op 1) emits its data byte; after the
// last payload byte the CRC over command, length and payload follows, low
// byte first, then tail_byte with frame_end set. A start whose length plus
// seven exceeds max_frame_length gives a single result with rejected and
// frame_end set and out_byte zero. Payload with no frame open is dropped.
// Rate: every input transaction is worked out in the cycle it is accepted
// and its results land in a seven-entry burst buffer that drains one byte
// per cycle while out_stall is low. A transaction with one result (mid-frame
// payload) is accepted every cycle while out_stall is low; one with n results
// holds in_stall until its last result leaves (start: 4, last payload: 4, empty: 7).
module serial_frame_builder_crc16_unit
  import sfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_op,
  input  logic [7:0]  in_command,
  input  logic [7:0]  in_payload_length,
  input  logic [7:0]  in_data_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_frame_end,
  output logic        out_rejected
);

  // configuration registers
  logic [7:0]  header_first_r, header_second_r, tail_byte_r;
  logic [8:0]  max_frame_len_r;
  logic [15:0] crc_initial_r;

  // frame state
  logic        frame_open_r, frame_open_nxt;
  logic [7:0]  remaining_r, remaining_nxt;
  logic [15:0] crc_r, crc_nxt;

  logic        buf_ready;
  logic        in_accept;
  burst_load_t ld;
  frame_byte_t head;

  // per-transaction combinational terms
  logic [15:0] crc_cmd, crc_hdr, crc_data;
  logic [7:0]  rem_dec;
  logic        too_long;

  assign in_stall  = !buf_ready;
  assign in_accept = in_valid && buf_ready;

  assign crc_cmd  = crc16_byte(crc_initial_r, in_command);
  assign crc_hdr  = crc16_byte(crc_cmd, in_payload_length);
  assign crc_data = crc16_byte(crc_r, in_data_byte);
  assign rem_dec  = remaining_r - 8'd1;
  assign too_long = ({1'b0, in_payload_length} + OVERHEAD_BYTES) > max_frame_len_r;

  // build the result burst and the next frame state
  always_comb begin
    ld             = '0;
    frame_open_nxt = frame_open_r;
    remaining_nxt  = remaining_r;
    crc_nxt        = crc_r;
    if (in_op == OP_START) begin
      frame_open_nxt = 1'b0;
      remaining_nxt  = 8'd0;
      if (too_long) begin
        ld.cnt    = BURST_CNT_W'(1);
        ld.ent[0] = '{data: 8'h00, frame_end: 1'b1, rejected: 1'b1};
      end else begin
        crc_nxt   = crc_hdr;
        ld.ent[0] = '{data: header_first_r,    frame_end: 1'b0, rejected: 1'b0};
        ld.ent[1] = '{data: header_second_r,   frame_end: 1'b0, rejected: 1'b0};
        ld.ent[2] = '{data: in_command,        frame_end: 1'b0, rejected: 1'b0};
        ld.ent[3] = '{data: in_payload_length, frame_end: 1'b0, rejected: 1'b0};
        if (in_payload_length == 8'd0) begin
          // empty payload: close the frame at once
          ld.cnt    = BURST_CNT_W'(7);
          ld.ent[4] = '{data: crc_hdr[7:0],  frame_end: 1'b0, rejected: 1'b0};
          ld.ent[5] = '{data: crc_hdr[15:8], frame_end: 1'b0, rejected: 1'b0};
          ld.ent[6] = '{data: tail_byte_r,   frame_end: 1'b1, rejected: 1'b0};
        end else begin
          ld.cnt         = BURST_CNT_W'(4);
          frame_open_nxt = 1'b1;
          remaining_nxt  = in_payload_length;
        end
      end
    end else if (frame_open_r) begin
      crc_nxt       = crc_data;
      remaining_nxt = rem_dec;
      ld.ent[0]     = '{data: in_data_byte, frame_end: 1'b0, rejected: 1'b0};
      if (rem_dec == 8'd0) begin
        // last payload byte: append CRC and tail
        ld.cnt         = BURST_CNT_W'(4);
        frame_open_nxt = 1'b0;
        ld.ent[1] = '{data: crc_data[7:0],  frame_end: 1'b0, rejected: 1'b0};
        ld.ent[2] = '{data: crc_data[15:8], frame_end: 1'b0, rejected: 1'b0};
        ld.ent[3] = '{data: tail_byte_r,    frame_end: 1'b1, rejected: 1'b0};
      end else begin
        ld.cnt = BURST_CNT_W'(1);
      end
    end
    // payload with no frame open: drop, no result
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_first_r  <= 8'd170;
      header_second_r <= 8'd85;
      tail_byte_r     <= 8'd13;
      max_frame_len_r <= 9'd128;
      crc_initial_r   <= 16'hFFFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_HEADER_FIRST:  header_first_r  <= cfg_wdata[7:0];
        CFG_HEADER_SECOND: header_second_r <= cfg_wdata[7:0];
        CFG_TAIL_BYTE:     tail_byte_r     <= cfg_wdata[7:0];
        CFG_MAX_FRAME_LEN: max_frame_len_r <= cfg_wdata[8:0];
        CFG_CRC_INITIAL:   crc_initial_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // advance frame state on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_open_r <= 1'b0;
      remaining_r  <= 8'd0;
      crc_r        <= 16'd0;
    end else if (in_accept) begin
      frame_open_r <= frame_open_nxt;
      remaining_r  <= remaining_nxt;
      crc_r        <= crc_nxt;
    end
  end

  sfb_burst_buf u_burst_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (in_accept),
    .ld        (ld),
    .out_stall (out_stall),
    .ready     (buf_ready),
    .out_valid (out_valid),
    .head      (head)
  );

  assign out_byte      = head.data;
  assign out_frame_end = head.frame_end;
  assign out_rejected  = head.rejected;

`ifndef SYNTHESIS
  a_open_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    frame_open_r |-> remaining_r != 8'd0)
    else $error("frame open with nothing left");
  a_reject_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_op == OP_START && too_long) |=> !frame_open_r)
    else $error("rejected start left a frame open");
  a_drop_closed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_op == OP_PAYLOAD && !frame_open_r) |=> !out_valid)
    else $error("payload with no frame produced a result");
`endif

endmodule

// ===== design/sfb_burst_buf.sv =====
module sfb_burst_buf
  import sfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  burst_load_t ld,
  input  logic        out_stall,
  output logic        ready,
  output logic        out_valid,
  output frame_byte_t head
);

  frame_byte_t [BURST_DEPTH-1:0] ent_r, ent_nxt;
  logic [BURST_CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                          pop;

  assign out_valid = (cnt_r != '0);
  assign head      = ent_r[0];
  assign pop       = out_valid && !out_stall;
  // take a new burst when empty or once the last pending byte leaves this cycle
  assign ready     = (cnt_r == '0) || ((cnt_r == BURST_CNT_W'(1)) && pop);

  always_comb begin
    ent_nxt = ent_r;
    cnt_nxt = cnt_r;
    if (load) begin
      ent_nxt = ld.ent;
      cnt_nxt = ld.cnt;
    end else if (pop) begin
      for (int i = 0; i < BURST_DEPTH - 1; i++) begin
        ent_nxt[i] = ent_r[i+1];
      end
      cnt_nxt = cnt_r - BURST_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

`ifndef SYNTHESIS
  a_load_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> ready)
    else $error("burst loaded over pending bytes");
  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> cnt_r == $past(ld.cnt))
    else $error("burst count not taken");
  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !load) |=> cnt_r == $past(cnt_r) - BURST_CNT_W'(1))
    else $error("pop did not retire one byte");
  a_reject_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && head.rejected) |-> (head.frame_end && head.data == 8'h00))
    else $error("rejection result malformed");
`endif

endmodule

// ===== sim/serial_frame_builder_crc16_unit_tb.sv =====
`timescale 1ns / 1ps

module serial_frame_builder_crc16_unit_tb
  import sfb_pkg::*;
();

  localparam int RANDOM_ITEMS   = 25;
  localparam int RX_HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 12;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int REPORT_LIMIT   = 10;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic        in_op;
  logic [7:0]  in_command;
  logic [7:0]  in_payload_length;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        out_frame_end;
  logic        out_rejected;

  // Shadow copy of the configuration registers
  logic [7:0]  hdr_first_q;
  logic [7:0]  hdr_second_q;
  logic [7:0]  tail_q;
  logic [8:0]  max_len_q;
  logic [15:0] crc_init_q;

  // Predicted frame state
  logic        frame_open_q;
  logic [7:0]  remain_q;
  logic [15:0] crc_q;

  // Bytes the block still owes us, oldest first
  frame_byte_t frame_bytes_due[$];

  int   mismatch_cnt;
  int   live_items;
  int   quiet_cycles;
  logic quiet_mode;   // no idling on either side
  logic rx_hold_req;  // ask the receiver for one long hold-off
  logic rx_hold_done; // receiver has served the hold-off

  serial_frame_builder_crc16_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_op             (in_op),
    .in_command        (in_command),
    .in_payload_length (in_payload_length),
    .in_data_byte      (in_data_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_frame_end     (out_frame_end),
    .out_rejected      (out_rejected)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------------

  // Fold one byte into the CCITT register, MSB first, no reflection
  function automatic logic [15:0] ccitt_fold(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {b, 8'h00};
    repeat (8) begin
      if (r[15]) begin
        r = (r << 1) ^ CRC_POLY;
      end else begin
        r = r << 1;
      end
    end
    return r;
  endfunction

  function automatic void queue_frame_byte(input logic [7:0] d, input logic fe, input logic rj);
    frame_byte_t fb;
    fb.data      = d;
    fb.frame_end = fe;
    fb.rejected  = rj;
    frame_bytes_due = {frame_bytes_due, fb};
  endfunction

  // CRC low byte, CRC high byte, then the tail closes the frame
  function automatic void close_frame();
    queue_frame_byte(crc_q[7:0], 1'b0, 1'b0);
    queue_frame_byte(crc_q[15:8], 1'b0, 1'b0);
    queue_frame_byte(tail_q, 1'b1, 1'b0);
    frame_open_q = 1'b0;
    remain_q     = '0;
  endfunction

  // Work out the bytes one accepted transaction causes; returns how many
  function automatic int predict_frame_bytes(input logic op, input logic [7:0] cmd,
                                             input logic [7:0] len, input logic [7:0] d);
    int depth_in;
    depth_in = frame_bytes_due.size();
    if (op == OP_START) begin
      // A new start always drops whatever frame was open
      frame_open_q = 1'b0;
      remain_q     = '0;
      if (int'(len) + int'(OVERHEAD_BYTES) > int'(max_len_q)) begin
        queue_frame_byte(8'h00, 1'b1, 1'b1);
      end else begin
        crc_q = crc_init_q;
        queue_frame_byte(hdr_first_q, 1'b0, 1'b0);
        queue_frame_byte(hdr_second_q, 1'b0, 1'b0);
        queue_frame_byte(cmd, 1'b0, 1'b0);
        queue_frame_byte(len, 1'b0, 1'b0);
        crc_q = ccitt_fold(crc_q, cmd);
        crc_q = ccitt_fold(crc_q, len);
        if (len == 8'd0) begin
          close_frame();
        end else begin
          frame_open_q = 1'b1;
          remain_q     = len;
        end
      end
    end else if (frame_open_q) begin
      queue_frame_byte(d, 1'b0, 1'b0);
      crc_q    = ccitt_fold(crc_q, d);
      remain_q = remain_q - 8'd1;
      if (remain_q == 8'd0) begin
        close_frame();
      end
    end
    return frame_bytes_due.size() - depth_in;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checker: compare every accepted output transaction with the oldest
  // pending prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    frame_byte_t want;
    frame_byte_t seen;
    if (rst_n && out_valid && !out_stall) begin
      seen.data      = out_byte;
      seen.frame_end = out_frame_end;
      seen.rejected  = out_rejected;
      if (frame_bytes_due.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= REPORT_LIMIT) begin
          $display("%0t: result with nothing pending: byte %02h end %b rej %b",
                   $time, seen.data, seen.frame_end, seen.rejected);
        end
      end else begin
        want = frame_bytes_due.pop_front();
        if (seen.data !== want.data || seen.frame_end !== want.frame_end ||
            seen.rejected !== want.rejected) begin
          mismatch_cnt++;
          if (mismatch_cnt <= REPORT_LIMIT) begin
            $display("%0t: mismatch: expected byte %02h end %b rej %b,",
                     $time, want.data, want.frame_end, want.rejected,
                     " got byte %02h end %b rej %b",
                     seen.data, seen.frame_end, seen.rejected);
          end
        end
      end
    end
  end

  // Watchdog: count cycles in which no transaction moves on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAIL serial_frame_builder_crc16_unit");
        $finish;
      end
    end
  end

  // Receiver pacing: random stall bursts, one long hold-off on request, and
  // nothing at all once quiet_mode is set
  initial begin : rx_pacing
    int span;
    out_stall    = 1'b0;
    rx_hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req && !rx_hold_done) begin
        out_stall = 1'b1;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        out_stall    = 1'b0;
        rx_hold_done = 1'b1;
      end else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
        span      = int'($urandom_range(1, 13));
        out_stall = 1'b1;
        repeat (span) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Drop valid for the given gap and scramble the idle payload
  task automatic tx_gap(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid          = 1'b0;
      in_op             = 1'($urandom_range(0, 1));
      in_command        = rand_byte();
      in_payload_length = rand_byte();
      in_data_byte      = rand_byte();
    end
  endtask

  // Offer one input transaction and hold it until the block takes it.
  // Valid stays high on return so back-to-back items stream without a gap.
  task automatic push_item(input logic op, input logic [7:0] cmd,
                           input logic [7:0] len, input logic [7:0] d);
    if (!quiet_mode && $urandom_range(0, 4) == 0) begin
      tx_gap(int'($urandom_range(1, 13)));
    end
    @(negedge clk);
    in_valid          = 1'b1;
    in_op             = op;
    in_command        = cmd;
    in_payload_length = len;
    in_data_byte      = d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (predict_frame_bytes(op, cmd, len, d) > 0) begin
      live_items++;
    end
  endtask

  task automatic push_payload(input logic [7:0] d);
    push_item(OP_PAYLOAD, rand_byte(), rand_byte(), d);
  endtask

  // Start a frame and feed `count` random payload bytes
  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] len, input int count);
    push_item(OP_START, cmd, len, rand_byte());
    repeat (count) push_payload(rand_byte());
  endtask

  // Go idle and let the block drain. Dropped payload leaves no trace in the
  // queue, so also wait out the burst latency before touching registers.
  task automatic settle_block();
    @(negedge clk);
    in_valid = 1'b0;
    while (frame_bytes_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we    = 1'b0;
    cfg_wdata = {8'h00, rand_byte()};
    case (idx)
      CFG_HEADER_FIRST:  hdr_first_q  = val[7:0];
      CFG_HEADER_SECOND: hdr_second_q = val[7:0];
      CFG_TAIL_BYTE:     tail_q       = val[7:0];
      CFG_MAX_FRAME_LEN: max_len_q    = val[8:0];
      CFG_CRC_INITIAL:   crc_init_q   = val;
      default: ;
    endcase
  endtask

  task automatic write_all_regs(input logic [7:0] hf, input logic [7:0] hs,
                                input logic [7:0] tl, input logic [8:0] ml,
                                input logic [15:0] ci);
    write_reg(CFG_HEADER_FIRST, {8'h00, hf});
    write_reg(CFG_HEADER_SECOND, {8'h00, hs});
    write_reg(CFG_TAIL_BYTE, {8'h00, tl});
    write_reg(CFG_MAX_FRAME_LEN, {7'd0, ml});
    write_reg(CFG_CRC_INITIAL, ci);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset configuration: empty frame, plain frame, stray payload, abandon,
  // rejection and the exact length boundary
  task automatic test_default_frames();
    push_item(OP_START, 8'h00, 8'd0, 8'hFF);
    push_item(OP_START, 8'hFF, 8'd3, 8'h00);
    push_payload(8'h00);
    push_payload(8'hFF);
    push_payload(8'h5A);
    push_payload(8'hC3);                      // no frame open: dropped
    push_item(OP_START, 8'h12, 8'd2, 8'h00);
    push_payload(8'h34);
    push_item(OP_START, 8'h56, 8'd1, 8'h00);  // abandon the open frame
    push_payload(8'h78);
    push_item(OP_START, 8'h9C, 8'd255, 8'h00);
    push_item(OP_START, 8'h21, 8'd121, 8'h00); // 121 + 7 hits the limit exactly
    push_payload(8'hA5);
    push_item(OP_START, 8'h42, 8'd122, 8'h00); // one over: rejected, frame dropped
    push_payload(8'hE7);
  endtask

  // Register extremes, including a limit below the overhead and the
  // longest legal frame length
  task automatic test_register_extremes();
    settle_block();
    write_all_regs(8'h00, 8'hFF, 8'hFF, 9'd7, 16'h0000);
    push_item(OP_START, 8'hA5, 8'd0, 8'h00);
    push_item(OP_START, 8'h5A, 8'd1, 8'h00);
    push_payload(8'h11);
    settle_block();
    write_reg(CFG_MAX_FRAME_LEN, 16'd3);
    push_item(OP_START, 8'h80, 8'd0, 8'h00);
    settle_block();
    write_all_regs(8'hFF, 8'h00, 8'h00, 9'd511, 16'hFFFF);
    send_frame(8'h01, 8'd1, 1);
    settle_block();
    write_reg(CFG_MAX_FRAME_LEN, 16'd262);
    push_item(OP_START, 8'hC7, 8'd255, 8'h00); // 255 + 7 opens at the top limit
    send_frame(8'h3C, 8'd2, 2);                // abandon it with a short frame
  endtask

  task automatic randomize_registers();
    logic [8:0] ml;
    case ($urandom_range(0, 7))
      0:       ml = 9'($urandom_range(0, 6));
      1:       ml = 9'd7;
      2, 3:    ml = 9'($urandom_range(8, 24));
      4, 5:    ml = 9'd128;
      6:       ml = 9'd262;
      default: ml = 9'd511;
    endcase
    write_all_regs(rand_byte(), rand_byte(), rand_byte(), ml,
                   16'($urandom_range(0, 65535)));
  endtask

  // Mostly complete frames with random content; the rest is stray payload,
  // oversized starts and frames cut short by the next start
  task automatic send_random_frame();
    logic [7:0] len;
    len = 8'($urandom_range(0, 12));
    case ($urandom_range(0, 9))
      0: push_payload(rand_byte());
      1: push_item(OP_START, rand_byte(), rand_byte(), rand_byte());
      2: send_frame(rand_byte(), len + 8'd1, int'($urandom_range(0, len)));
      default: send_frame(rand_byte(), len, int'(len));
    endcase
  endtask

  task automatic test_random_traffic();
    int base;
    base = live_items;
    while (live_items - base < RANDOM_ITEMS) begin
      settle_block();
      randomize_registers();
      repeat (6) send_random_frame();
    end
  endtask

  // Hold the receiver off while the sender keeps streaming a frame, so the
  // burst buffer fills and the input stalls
  task automatic test_backpressure();
    settle_block();
    write_reg(CFG_MAX_FRAME_LEN, 16'd128);
    rx_hold_req = 1'b1;
    send_frame(rand_byte(), 8'd16, 16);
    wait (rx_hold_done);
    rx_hold_req = 1'b0;
  endtask

  // Full rate on both sides for the last stretch
  task automatic test_steady_stream();
    quiet_mode = 1'b1;
    repeat (5) send_frame(rand_byte(), 8'($urandom_range(0, 12)), 0);
    repeat (4) begin
      send_random_frame();
    end
  endtask

  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_HEADER_FIRST;
    cfg_wdata         = '0;
    in_valid          = 1'b0;
    in_op             = OP_START;
    in_command        = '0;
    in_payload_length = '0;
    in_data_byte      = '0;
    quiet_mode        = 1'b0;
    rx_hold_req       = 1'b0;
    live_items        = 0;
    // Predictor starts from the reset configuration
    hdr_first_q       = 8'd170;
    hdr_second_q      = 8'd85;
    tail_q            = 8'd13;
    max_len_q         = 9'd128;
    crc_init_q        = 16'hFFFF;
    frame_open_q      = 1'b0;
    remain_q          = '0;
    crc_q             = '0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_frames();
    test_register_extremes();
    test_random_traffic();
    test_backpressure();
    test_steady_stream();

    // Drain, then wait out SETTLE_CYCLES so the block can show any extra bytes
    settle_block();
    if (mismatch_cnt == 0 && frame_bytes_due.size() == 0) begin
      $display("PASS serial_frame_builder_crc16_unit");
    end else begin
      $display("FAIL serial_frame_builder_crc16_unit");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sfb_pkg.sv
design/sfb_burst_buf.sv
design/serial_frame_builder_crc16_unit.sv
sim/serial_frame_builder_crc16_unit_tb.sv
